/* hw/rtl/hrhp_pkg.sv */
package hrhp_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int OUT_LEN_BITS    = 32;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam int KEY_LEN = 15;
  localparam logic [4:0] SUB_BLANKS  = 5'd15;
  localparam logic [4:0] SUB_DIGITS  = 5'd16;
  localparam logic [4:0] SUB_STOPPED = 5'd17;

  localparam logic [4:0] STATUS_MIN_LEN = 5'd13;
  localparam logic [4:0] LINE_POS_MAX   = 5'd31;
  localparam logic [4:0] CODE_FIRST     = 5'd9;
  localparam logic [4:0] CODE_LAST      = 5'd11;

  localparam logic [23:0] CODE_200 = 24'h323030;
  localparam logic [23:0] CODE_301 = 24'h333031;
  localparam logic [23:0] CODE_302 = 24'h333032;

  localparam logic [1:0] PH_STATUS  = 2'd0;
  localparam logic [1:0] PH_HEADERS = 2'd1;
  localparam logic [1:0] PH_BODY    = 2'd2;

  localparam logic [1:0] LS_SEARCH = 2'd0;
  localparam logic [1:0] LS_SKIP   = 2'd1;
  localparam logic [1:0] LS_VALUE  = 2'd2;
  localparam logic [1:0] LS_FOUND  = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_200   = 2'd1;
  localparam logic [1:0] KIND_301   = 2'd2;
  localparam logic [1:0] KIND_302   = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BARE_CR   = 2'd1;
  localparam logic [1:0] ERR_NO_LENGTH = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               new_response;
    logic               last_byte;
    logic               is_cr;
    logic               is_lf;
    logic               is_digit;
    logic               is_blank;
    logic [3:0]         digit;
    logic [KEY_LEN-1:0] key_hit;
  } class_t;

  function automatic logic [7:0] keyword_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "l";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/hrhp_ifs.sv */
interface hrhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_response;
  logic       last_byte;

  modport source(output valid, data_byte, new_response, last_byte, input ready);
  modport sink(input valid, data_byte, new_response, last_byte, output ready);
endinterface

interface hrhp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status_kind;
  logic        length_found;
  logic [31:0] length_value;
  logic        headers_done;
  logic        body_complete;
  logic [1:0]  error_code;

  modport source(output valid, status_kind, length_found, length_value, headers_done,
                 body_complete, error_code, input ready);
  modport sink(input valid, status_kind, length_found, length_value, headers_done,
               body_complete, error_code, output ready);
endinterface

/* hw/rtl/hrhp_front.sv */
module hrhp_front (
  hrhp_byte_if.sink        stream,
  input  logic             full,
  output logic             push,
  output hrhp_pkg::class_t push_item
);
  import hrhp_pkg::*;

  logic [7:0] lower;

  assign stream.ready = !full;
  assign push         = stream.valid && !full;

  assign lower = (stream.data_byte >= "A" && stream.data_byte <= "Z") ?
                 stream.data_byte + 8'd32 : stream.data_byte;

  always_comb begin
    push_item.data_byte    = stream.data_byte;
    push_item.new_response = stream.new_response;
    push_item.last_byte    = stream.last_byte;
    push_item.is_cr        = stream.data_byte == CHAR_CR;
    push_item.is_lf        = stream.data_byte == CHAR_LF;
    push_item.is_digit     = stream.data_byte >= "0" && stream.data_byte <= "9";
    push_item.is_blank     = stream.data_byte == 8'h20 || stream.data_byte == 8'h09 ||
                             stream.data_byte == 8'h0B || stream.data_byte == 8'h0C;
    push_item.digit        = 4'(stream.data_byte - "0");
    for (int i = 0; i < KEY_LEN; i++) begin
      push_item.key_hit[i] = lower == keyword_char(4'(i));
    end
  end

endmodule

/* hw/rtl/hrhp_queue.sv */
module hrhp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hrhp_pkg::class_t push_item,
  output logic             full,
  input  logic             pop,
  output hrhp_pkg::class_t head,
  output logic             nonempty
);
  import hrhp_pkg::*;

  class_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !nonempty))
    else $error("queue read while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
                                   (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a transfer");

endmodule

/* hw/rtl/hrhp_back.sv */
module hrhp_back #(
  parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  hrhp_pkg::class_t item,
  input  logic             nonempty,
  output logic             pop,
  hrhp_result_if.source    result
);
  import hrhp_pkg::*;

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic [1:0]             phase, phase_next;
  logic [4:0]             line_pos, line_pos_next;
  logic [23:0]            code_digits, code_digits_next;
  logic [1:0]             status_class, status_class_next;
  logic                   pending_cr, pending_cr_next;
  logic [4:0]             key_count, key_count_next;
  logic [LENGTH_BITS-1:0] length_acc, length_acc_next;
  logic [1:0]             length_state, length_state_next;
  logic [1:0]             term_match, term_match_next;
  logic [LENGTH_BITS-1:0] body_count, body_count_next;
  logic [1:0]             error_flags, error_flags_next;
  logic                   ended;
  logic [LENGTH_BITS+3:0] acc_ext;
  logic [31:0]            len32;

  logic                   res_valid;
  logic [1:0]             res_kind;
  logic                   res_found;
  logic [31:0]            res_length;
  logic                   res_done;
  logic                   res_complete;
  logic [1:0]             res_error;

  assign pop = nonempty && (!res_valid || result.ready);

  always_comb begin
    if (item.new_response) begin
      phase_next        = PH_STATUS;
      line_pos_next     = '0;
      code_digits_next  = '0;
      status_class_next = KIND_OTHER;
      pending_cr_next   = 1'b0;
      key_count_next    = '0;
      length_acc_next   = '0;
      length_state_next = LS_SEARCH;
      term_match_next   = '0;
      body_count_next   = '0;
      error_flags_next  = ERR_NONE;
    end else begin
      phase_next        = phase;
      line_pos_next     = line_pos;
      code_digits_next  = code_digits;
      status_class_next = status_class;
      pending_cr_next   = pending_cr;
      key_count_next    = key_count;
      length_acc_next   = length_acc;
      length_state_next = length_state;
      term_match_next   = term_match;
      body_count_next   = body_count;
      error_flags_next  = error_flags;
    end
    ended   = 1'b0;
    acc_ext = ({4'b0, length_acc_next} << 3) + ({4'b0, length_acc_next} << 1) +
              (LENGTH_BITS + 4)'(item.digit);

    if (phase_next != PH_BODY) begin
      case (length_state_next)
        LS_SEARCH: begin
          if (key_count_next < 5'(KEY_LEN) && item.key_hit[key_count_next[3:0]]) begin
            key_count_next = key_count_next + 5'd1;
          end else begin
            key_count_next = item.key_hit[0] ? 5'd1 : 5'd0;
          end
          if (key_count_next >= 5'(KEY_LEN)) length_state_next = LS_SKIP;
        end
        LS_SKIP: begin
          if (item.is_cr || item.is_lf) begin
            length_state_next = LS_FOUND;
          end else begin
            length_state_next = LS_VALUE;
            key_count_next    = SUB_BLANKS;
          end
        end
        LS_VALUE: begin
          if (item.is_cr || item.is_lf) begin
            length_state_next = LS_FOUND;
          end else if (item.is_digit && key_count_next != SUB_STOPPED) begin
            length_acc_next = (acc_ext > {4'b0, LenMax}) ? LenMax : acc_ext[LENGTH_BITS-1:0];
            key_count_next  = SUB_DIGITS;
          end else if (!(item.is_blank && key_count_next == SUB_BLANKS)) begin
            key_count_next = SUB_STOPPED;
          end
        end
        default: begin
        end
      endcase

      if (term_match_next == 2'd3 && item.is_lf) begin
        term_match_next = 2'd0;
        ended           = 1'b1;
      end else if ((term_match_next == 2'd0 || term_match_next == 2'd2) && item.is_cr) begin
        term_match_next = term_match_next + 2'd1;
      end else if (term_match_next == 2'd1 && item.is_lf) begin
        term_match_next = 2'd2;
      end else begin
        term_match_next = item.is_cr ? 2'd1 : 2'd0;
      end

      if (phase_next == PH_STATUS) begin
        if (pending_cr_next) begin
          pending_cr_next   = 1'b0;
          phase_next        = PH_HEADERS;
          status_class_next = KIND_OTHER;
          if (item.is_lf) begin
            if (line_pos_next >= STATUS_MIN_LEN) begin
              if (code_digits_next == CODE_200) status_class_next = KIND_200;
              else if (code_digits_next == CODE_302) status_class_next = KIND_302;
              else if (code_digits_next == CODE_301) status_class_next = KIND_301;
            end
          end else if (error_flags_next == ERR_NONE) begin
            error_flags_next = ERR_BARE_CR;
          end
        end else if (item.is_cr) begin
          pending_cr_next = 1'b1;
        end else begin
          if (line_pos_next >= CODE_FIRST && line_pos_next <= CODE_LAST) begin
            code_digits_next = {code_digits_next[15:0], item.data_byte};
          end
          if (line_pos_next < LINE_POS_MAX) line_pos_next = line_pos_next + 5'd1;
        end
      end

      if (ended) begin
        phase_next = PH_BODY;
        if (length_state_next != LS_FOUND && error_flags_next == ERR_NONE) begin
          error_flags_next = ERR_NO_LENGTH;
        end
      end
    end else begin
      if (!(length_state_next == LS_FOUND && body_count_next == length_acc_next) &&
          body_count_next < LenMax) begin
        body_count_next = body_count_next + LENGTH_BITS'(1);
      end
    end

    if (item.last_byte && phase_next != PH_BODY && error_flags_next == ERR_NONE) begin
      error_flags_next = ERR_TRUNCATED;
    end
  end

  generate
    if (LENGTH_BITS > OUT_LEN_BITS) begin : g_sat
      assign len32 = (|length_acc_next[LENGTH_BITS-1:OUT_LEN_BITS]) ? '1 :
                     length_acc_next[OUT_LEN_BITS-1:0];
    end else begin : g_ext
      assign len32 = OUT_LEN_BITS'(length_acc_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STATUS;
      line_pos     <= '0;
      code_digits  <= '0;
      status_class <= KIND_OTHER;
      pending_cr   <= 1'b0;
      key_count    <= '0;
      length_acc   <= '0;
      length_state <= LS_SEARCH;
      term_match   <= '0;
      body_count   <= '0;
      error_flags  <= ERR_NONE;
      res_valid    <= 1'b0;
    end else begin
      if (pop) begin
        phase        <= phase_next;
        line_pos     <= line_pos_next;
        code_digits  <= code_digits_next;
        status_class <= status_class_next;
        pending_cr   <= pending_cr_next;
        key_count    <= key_count_next;
        length_acc   <= length_acc_next;
        length_state <= length_state_next;
        term_match   <= term_match_next;
        body_count   <= body_count_next;
        error_flags  <= error_flags_next;
        res_valid    <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_kind     <= status_class_next;
      res_found    <= length_state_next == LS_FOUND;
      res_length   <= len32;
      res_done     <= phase_next == PH_BODY;
      res_complete <= phase_next == PH_BODY && length_state_next == LS_FOUND &&
                      body_count_next == length_acc_next;
      res_error    <= error_flags_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.status_kind   = res_kind;
  assign result.length_found  = res_found;
  assign result.length_value  = res_length;
  assign result.headers_done  = res_done;
  assign result.body_complete = res_complete;
  assign result.error_code    = res_error;

  a_body_bounded: assert property (@(posedge clk) disable iff (rst)
                                   (phase == PH_BODY && length_state == LS_FOUND) |->
                                   body_count <= length_acc)
    else $error("body count passed the length");
  a_term_idle: assert property (@(posedge clk) disable iff (rst)
                                phase == PH_BODY |-> (term_match == 2'd0 && !pending_cr))
    else $error("header matcher active in body");
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
                                   (error_flags != ERR_NONE && !(pop && item.new_response)) |=>
                                   error_flags == $past(error_flags))
    else $error("error code changed without a new response");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
                                  (res_valid && !result.ready) |=> !$past(pop))
    else $error("result overwritten while stalled");

endmodule

/* hw/rtl/http_response_header_parser.sv */
// A byte enters the queue slot; its result is registered when the back end pops it.
// Throughput: one byte per cycle while result.ready does not stall the back end.
// A two-entry queue separates byte classification from the state update.
// Reset (rst, synchronous, active high) clears all parse state, the queue and the result.
// A byte with new_response set clears parse state before it is processed.
module http_response_header_parser #(
  parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  hrhp_byte_if.sink     stream,
  hrhp_result_if.source result
);
  import hrhp_pkg::*;

  class_t push_item;
  class_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   nonempty;

  hrhp_front u_front (
    .stream    (stream),
    .full      (full),
    .push      (push),
    .push_item (push_item)
  );

  hrhp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .nonempty  (nonempty)
  );

  hrhp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .item     (head),
    .nonempty (nonempty),
    .pop      (pop),
    .result   (result)
  );

endmodule
